// ===== design/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int DATA_WIDTH_DEF = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_LINK,
      S_FIX,
      S_DONE
   } ple_state_type;

   typedef enum logic [1:0] {
      INS_FIRST,
      INS_HEAD,
      INS_TAIL,
      INS_MID
   } ple_ins_type;

endpackage

// ===== design/ple_node_ram.sv =====
// Node store: value, next link and prev link per slot, one registered read port.
`timescale 1ns / 1ps
module ple_node_ram #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32,
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic                  clock,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_value,
   output logic [AW-1:0]         rd_next,
   output logic [AW-1:0]         rd_prev,
   input  logic                  val_we,
   input  logic [AW-1:0]         val_addr,
   input  logic [DATA_WIDTH-1:0] val_data,
   input  logic                  next_we,
   input  logic [AW-1:0]         next_addr,
   input  logic [AW-1:0]         next_data,
   input  logic                  prev_we,
   input  logic [AW-1:0]         prev_addr,
   input  logic [AW-1:0]         prev_data
);

   logic [DATA_WIDTH-1:0] value_mem [CAPACITY];
   logic [AW-1:0]         next_mem  [CAPACITY];
   logic [AW-1:0]         prev_mem  [CAPACITY];

   always_ff @(posedge clock) begin
      if (val_we) begin
         value_mem[val_addr] <= val_data;
      end
      rd_value <= value_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_addr] <= next_data;
      end
      rd_next <= next_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_addr] <= prev_data;
      end
      rd_prev <= prev_mem[rd_addr];
   end

endmodule

// ===== design/ple_free_stack.sv =====
// Free-slot stack; entries never written read as their reset order via a low-water mark.
`timescale 1ns / 1ps
module ple_free_stack #(
   parameter int CAPACITY = 64,
   localparam int AW = $clog2(CAPACITY)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   output logic [AW-1:0] rd_slot,
   input  logic          pop,
   input  logic          push,
   input  logic [AW-1:0] push_slot,
   output logic [AW:0]   top
);

   logic [AW-1:0] stack_mem [CAPACITY];
   logic [AW:0]   top_ff, top_in;
   logic [AW:0]   low_ff, low_in;
   logic [AW-1:0] rd_idx;
   logic [AW-1:0] mem_q;
   logic          fresh_ff;
   logic [AW-1:0] fresh_val_ff;

   assign top    = top_ff;
   assign rd_idx = AW'(top_ff - 1'b1);

   always_comb begin
      top_in = top_ff;
      low_in = low_ff;
      if (pop) begin
         top_in = top_ff - 1'b1;
         if (top_in < low_ff) begin
            low_in = top_in;
         end
      end else if (push) begin
         top_in = top_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= (AW+1)'(CAPACITY);
         low_ff <= (AW+1)'(CAPACITY);
      end else begin
         top_ff <= top_in;
         low_ff <= low_in;
      end
   end

   // below the low-water mark an entry reads as its reset value
   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[AW'(top_ff)] <= push_slot;
      end
      if (rd_en) begin
         mem_q        <= stack_mem[rd_idx];
         fresh_ff     <= ({1'b0, rd_idx} < low_ff);
         fresh_val_ff <= AW'(CAPACITY - 1) - rd_idx;
      end
   end

   assign rd_slot = fresh_ff ? fresh_val_ff : mem_q;

endmodule

// ===== design/positional_list_engine.sv =====
// Top level of the positional list engine: sequencer, list registers and result register.
`timescale 1ns / 1ps
// One request at a time. A request that ends at decode (position out of range, store full,
// unused op) goes from decode straight to done. A read or delete walks, then finishes; the walk
// follows at most count/2 links from the nearer end. An insert into an empty list links and
// finishes, an insert at the head or the tail links and then fixes the neighbour's link, and an
// insert in the middle walks, links and fixes. The walk is bound by the node store read port,
// one link read per cycle. A result held by a stalled receiver keeps the block in its done
// state until the result register frees up. The free stack needs no clearing pass on reset.
// status in tuser; out-of-range positions give status 1, an insert into a full store gives
// status 2.
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int AW      = $clog2(CAPACITY),
   localparam int CW      = $clog2(CAPACITY + 1),
   localparam int REQ_W   = ((CW + DATA_WIDTH + 7) / 8) * 8,
   localparam int RSP_W   = ((DATA_WIDTH + CW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // position, write_value
   input  logic [1:0]       req_tuser,  // op
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // read_value, entry_count
   output logic [1:0]       rsp_tuser   // status
);

   ple_state_type state_ff, state_in;
   ple_ins_type   kind_ff, kind_in;

   logic [1:0]            op_ff, op_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [AW-1:0]         head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         cur_ff, cur_in, s_ff, s_in, p_ff, p_in, n_ff, n_in;
   logic [CW-1:0]         steps_ff, steps_in;
   logic                  fwd_ff, fwd_in;
   logic [1:0]            res_st_ff, res_st_in;
   logic [DATA_WIDTH-1:0] res_rd_ff, res_rd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            out_st_ff, out_st_in;
   logic [DATA_WIDTH-1:0] out_rd_ff, out_rd_in;
   logic [CW-1:0]         out_cnt_ff, out_cnt_in;

   logic                  req_acc;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_value;
   logic [AW-1:0]         rd_next, rd_prev;
   logic                  val_we, next_we, prev_we;
   logic [AW-1:0]         next_addr, next_data, prev_addr, prev_data;
   logic                  stk_pop, stk_push;
   logic [AW-1:0]         stk_slot;
   logic [AW:0]           stk_top;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_st_ff;
   assign rsp_tdata  = RSP_W'({out_cnt_ff, out_rd_ff});

   ple_node_ram #(.CAPACITY(CAPACITY), .DATA_WIDTH(DATA_WIDTH)) u_ram (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .rd_value  (rd_value),
      .rd_next   (rd_next),
      .rd_prev   (rd_prev),
      .val_we    (val_we),
      .val_addr  (n_ff),
      .val_data  (val_ff),
      .next_we   (next_we),
      .next_addr (next_addr),
      .next_data (next_data),
      .prev_we   (prev_we),
      .prev_addr (prev_addr),
      .prev_data (prev_data)
   );

   ple_free_stack #(.CAPACITY(CAPACITY)) u_stack (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_acc),
      .rd_slot   (stk_slot),
      .pop       (stk_pop),
      .push      (stk_push),
      .push_slot (cur_ff),
      .top       (stk_top)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      s_in         = s_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      steps_in     = steps_ff;
      fwd_in       = fwd_ff;
      res_st_in    = res_st_ff;
      res_rd_in    = res_rd_ff;
      rsp_valid_in = rsp_valid_ff;
      out_st_in    = out_st_ff;
      out_rd_in    = out_rd_ff;
      out_cnt_in   = out_cnt_ff;
      rd_addr      = cur_ff;
      val_we       = 1'b0;
      next_we      = 1'b0;
      prev_we      = 1'b0;
      next_addr    = n_ff;
      next_data    = n_ff;
      prev_addr    = n_ff;
      prev_data    = n_ff;
      stk_pop      = 1'b0;
      stk_push     = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               op_in     = req_tuser;
               pos_in    = req_tdata[CW-1:0];
               val_in    = req_tdata[CW +: DATA_WIDTH];
               res_st_in = ST_OK;
               res_rd_in = '0;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            if (pos_ff < (count_ff >> 1)) begin
               cur_in   = head_ff;
               steps_in = pos_ff;
               fwd_in   = 1'b1;
            end else begin
               cur_in   = tail_ff;
               steps_in = count_ff - pos_ff - 1'b1;
               fwd_in   = 1'b0;
            end
            case (op_ff)
               OP_INSERT: begin
                  n_in = stk_slot;
                  if (pos_ff > count_ff) begin
                     res_st_in = ST_RANGE;
                  end else if (count_ff == CW'(CAPACITY)) begin
                     res_st_in = ST_FULL;
                  end else if (count_ff == '0) begin
                     kind_in  = INS_FIRST;
                     state_in = S_LINK;
                  end else if (pos_ff == '0) begin
                     kind_in  = INS_HEAD;
                     s_in     = head_ff;
                     state_in = S_LINK;
                  end else if (pos_ff == count_ff) begin
                     kind_in  = INS_TAIL;
                     p_in     = tail_ff;
                     state_in = S_LINK;
                  end else begin
                     kind_in  = INS_MID;
                     rd_addr  = cur_in;
                     state_in = S_WALK;
                  end
               end
               OP_DELETE, OP_READ: begin
                  if (pos_ff >= count_ff) begin
                     res_st_in = ST_RANGE;
                  end else begin
                     rd_addr  = cur_in;
                     state_in = S_WALK;
                  end
               end
               default: begin
                  res_st_in = ST_OK;
               end
            endcase
         end
         S_WALK: begin
            if (steps_ff != '0) begin
               cur_in   = fwd_ff ? rd_next : rd_prev;
               rd_addr  = cur_in;
               steps_in = steps_ff - 1'b1;
            end else begin
               state_in = S_DONE;
               case (op_ff)
                  OP_READ: begin
                     res_rd_in = rd_value;
                  end
                  OP_DELETE: begin
                     stk_push = 1'b1;
                     count_in = count_ff - 1'b1;
                     if (count_ff == CW'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else if (pos_ff == '0) begin
                        head_in = rd_next;
                     end else if (pos_ff == count_ff - 1'b1) begin
                        tail_in = rd_prev;
                     end else begin
                        next_we   = 1'b1;
                        next_addr = rd_prev;
                        next_data = rd_next;
                        prev_we   = 1'b1;
                        prev_addr = rd_next;
                        prev_data = rd_prev;
                     end
                  end
                  default: begin
                     s_in     = cur_ff;
                     p_in     = rd_prev;
                     state_in = S_LINK;
                  end
               endcase
            end
         end
         S_LINK: begin
            val_we   = 1'b1;
            next_we  = 1'b1;
            prev_we  = 1'b1;
            stk_pop  = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = S_FIX;
            case (kind_ff)
               INS_FIRST: begin
                  head_in  = n_ff;
                  tail_in  = n_ff;
                  state_in = S_DONE;
               end
               INS_HEAD: begin
                  next_data = s_ff;
                  head_in   = n_ff;
               end
               INS_TAIL: begin
                  prev_data = p_ff;
                  tail_in   = n_ff;
               end
               default: begin
                  next_data = s_ff;
                  prev_data = p_ff;
               end
            endcase
         end
         S_FIX: begin
            next_we   = (kind_ff == INS_TAIL) || (kind_ff == INS_MID);
            next_addr = p_ff;
            prev_we   = (kind_ff == INS_HEAD) || (kind_ff == INS_MID);
            prev_addr = s_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               out_st_in    = res_st_ff;
               out_rd_in    = res_rd_ff;
               out_cnt_in   = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      cur_ff     <= cur_in;
      s_ff       <= s_in;
      p_ff       <= p_in;
      n_ff       <= n_in;
      steps_ff   <= steps_in;
      fwd_ff     <= fwd_in;
      res_st_ff  <= res_st_in;
      res_rd_ff  <= res_rd_in;
      out_st_ff  <= out_st_in;
      out_rd_ff  <= out_rd_in;
      out_cnt_ff <= out_cnt_in;
   end

`ifndef SYNTHESIS
   a_slots_conserved: assert property (@(posedge clock) disable iff (reset)
      ((AW+1)'(count_ff) + stk_top) == (AW+1)'(CAPACITY))
      else $error("free slots and entries do not add up to capacity");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_walk_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && steps_ff != '0) |=> (steps_ff == $past(steps_ff) - 1'b1))
      else $error("walk step counter did not advance");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == S_DECODE))
      else $error("accepted request not decoded");
`endif

endmodule

// ===== test/tb_positional_list_engine.sv =====
// Self-checking testbench for the positional list engine: insert, delete and read requests.
`timescale 1ns / 1ps
module tb_positional_list_engine;
   import ple_pkg::*;

   localparam int CAP   = 64;
   localparam int REQ_W = 40;
   localparam int RSP_W = 40;
   localparam int NUM_RANDOM = 1750;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] read_value;
      logic [6:0]  entry_count;
   } list_result_type;

   typedef struct {
      logic [1:0]  op;
      logic [6:0]  position;
      logic [31:0] write_value;
      bit          typed;
      list_result_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;  // position, write_value
   logic [1:0]       req_tuser = '0;  // op
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;       // read_value, entry_count
   logic [1:0]       rsp_tuser;       // status

   // the list itself, index 0 is the head
   logic [31:0]  list_values[$];
   list_result_type pending_results[$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           hold_rsp_pattern = 1'b0;

   positional_list_engine u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic list_result_type apply_list_op(logic [1:0] op, logic [6:0] pos,
                                                     logic [31:0] wval);
      list_result_type r;
      r = '0;
      case (op)
         OP_INSERT: begin
            if (pos > list_values.size()) r.status = ST_RANGE;
            else if (list_values.size() >= CAP) r.status = ST_FULL;
            else list_values.insert(pos, wval);
         end
         OP_DELETE: begin
            if (pos >= list_values.size()) r.status = ST_RANGE;
            else list_values.delete(pos);
         end
         OP_READ: begin
            if (pos >= list_values.size()) r.status = ST_RANGE;
            else r.read_value = list_values[pos];
         end
         default: ;
      endcase
      r.entry_count = 7'(list_values.size());
      return r;
   endfunction

   // receiver: stalls on a pseudo-random (LFSR) pattern, checks each result
   logic [15:0] stall_pattern = 16'b1011_0011_1000_1111;
   always @(posedge clock) begin
      list_result_type got, exp_r;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tuser;
         got.read_value  = rsp_tdata[31:0];
         got.entry_count = rsp_tdata[38:32];
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (got.status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
               error_count++;
            end
            if (got.read_value !== exp_r.read_value) begin
               $display("%0t: read_value expected %h actual %h", $time,
                        exp_r.read_value, got.read_value);
               error_count++;
            end
            if (got.entry_count !== exp_r.entry_count) begin
               $display("%0t: entry_count expected %0d actual %0d", $time,
                        exp_r.entry_count, got.entry_count);
               error_count++;
            end
         end
      end
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15] ^ stall_pattern[13]};
      rsp_tready <= hold_rsp_pattern ? 1'b1 : stall_pattern[0];
   end

   int burst_left = 0;

   // valid stays high through a burst and drops only for a gap
   task automatic send_request(logic [1:0] op, logic [6:0] pos, logic [31:0] wval,
                               bit typed, list_result_type want);
      list_result_type pred;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, wval, pos};
      do @(posedge clock); while (!req_tready);
      pred = apply_list_op(op, pos, wval);
      if (typed && pred !== want) begin
         $display("%0t: table row expected %p predicted %p", $time, want, pred);
         error_count++;
      end
      pending_results.push_back(pred);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   stim_row_type directed[$];

   function automatic void add_row(logic [1:0] op, logic [6:0] pos, logic [31:0] wval,
                                   bit typed, logic [1:0] st, logic [31:0] rd, logic [6:0] cnt);
      stim_row_type row;
      row.op = op; row.position = pos; row.write_value = wval; row.typed = typed;
      row.want.status = st; row.want.read_value = rd; row.want.entry_count = cnt;
      directed.push_back(row);
   endfunction

   initial begin
      list_result_type none;
      int op_pick, sz;
      logic [1:0] op;
      logic [6:0] pos;
      none = '0;
      // empty list, out of range and unused op, then inserts, reads and deletes back to empty
      add_row(OP_READ,   7'd0,   32'h0,        1, ST_RANGE, 32'h0, 7'd0);
      add_row(OP_DELETE, 7'd0,   32'h0,        1, ST_RANGE, 32'h0, 7'd0);
      add_row(OP_INSERT, 7'd1,   32'h1,        1, ST_RANGE, 32'h0, 7'd0);
      add_row(OP_INSERT, 7'd127, 32'h1,        1, ST_RANGE, 32'h0, 7'd0);
      add_row(2'd3,      7'd0,   32'hFFFF_FFFF,1, ST_OK,    32'h0, 7'd0);
      add_row(OP_INSERT, 7'd0,   32'hFFFF_FFFF,1, ST_OK,    32'h0, 7'd1);
      add_row(OP_READ,   7'd0,   32'h0,        1, ST_OK,    32'hFFFF_FFFF, 7'd1);
      add_row(OP_INSERT, 7'd0,   32'h0,        0, 0, 0, 0);
      add_row(OP_INSERT, 7'd2,   32'hA5A5_5A5A, 0, 0, 0, 0);
      add_row(OP_INSERT, 7'd1,   32'h1234_5678, 0, 0, 0, 0);
      add_row(OP_READ,   7'd1,   32'h0,        0, 0, 0, 0);
      add_row(OP_READ,   7'd3,   32'h0,        0, 0, 0, 0);
      add_row(OP_READ,   7'd4,   32'h0,        1, ST_RANGE, 32'h0, 7'd4);
      add_row(OP_DELETE, 7'd1,   32'h0,        0, 0, 0, 0);
      add_row(OP_DELETE, 7'd2,   32'h0,        0, 0, 0, 0);
      add_row(OP_DELETE, 7'd0,   32'h0,        0, 0, 0, 0);
      add_row(OP_DELETE, 7'd0,   32'h0,        1, ST_OK, 32'h0, 7'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i])
         send_request(directed[i].op, directed[i].position, directed[i].write_value,
                      directed[i].typed, directed[i].want);
      // fill to capacity, then full status at both ends and out-of-range past the end
      for (int i = 0; i < CAP; i++)
         send_request(OP_INSERT, 7'($urandom_range(0, i)), $urandom, 0, none);
      send_request(OP_INSERT, 7'd64, 32'h5, 1, '{ST_FULL, 32'h0, 7'd64});
      send_request(OP_INSERT, 7'd0, 32'h5, 1, '{ST_FULL, 32'h0, 7'd64});
      send_request(OP_INSERT, 7'd65, 32'h5, 1, '{ST_RANGE, 32'h0, 7'd64});
      send_request(OP_READ, 7'd63, 32'h0, 0, none);
      send_request(OP_DELETE, 7'd64, 32'h0, 1, '{ST_RANGE, 32'h0, 7'd64});
      // sender holds off until all results are back, receiver always ready
      wait_drained();
      hold_rsp_pattern = 1'b1;
      repeat (20) @(posedge clock);
      hold_rsp_pattern = 1'b0;

      for (int n = 0; n < NUM_RANDOM; n++) begin
         sz = list_values.size();
         op_pick = $urandom_range(0, 99);
         // bias toward growing or shrinking in long phases
         if (op_pick < (((n / 300) % 2) ? 25 : 45)) op = OP_INSERT;
         else if (op_pick < 70) op = OP_DELETE;
         else if (op_pick < 97) op = OP_READ;
         else op = 2'd3;
         if ($urandom_range(0, 19) == 0) pos = 7'($urandom_range(0, 127));
         else pos = 7'($urandom_range(0, (op == OP_INSERT) ? sz : (sz == 0 ? 0 : sz - 1)));
         send_request(op, pos, $urandom, 0, none);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
